// File: rtl/pert_pkg.sv
// ----------------------------------------------------------------------------
// pert_pkg: shared definitions for the ECAM region table
// Table depth, field widths, status codes and the stored entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package pert_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int BASE_W = 64;
  localparam int SEG_W = 16;
  localparam int BUS_W = 8;
  localparam int STATUS_W = 3;
  localparam int SLOT_W = 4;
  localparam int STORED_W = 5;
  localparam int COUNT_W = 32;
  localparam int ENTRY_W = SEG_W + 2 * BUS_W;

  localparam int ADDR_LIMIT_BITS = 52;
  localparam int MIB_SHIFT = 20;
  localparam logic [BASE_W-1:0] ALIGN_MASK = 64'h0000_0000_000f_ffff;

  localparam logic [STATUS_W-1:0] ST_STORED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERLAP = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    r = (v == '1) ? v : v + COUNT_W'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/pert_ram.sv
// ----------------------------------------------------------------------------
// pert_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pert_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                          wr_data,
  input  wire logic                                      rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/pert_field_chk.sv
// ----------------------------------------------------------------------------
// pert_field_chk: region field validation
// Flags a zero, unaligned or too high base, a reversed bus range, and a
// region whose buses 0 through last_bus do not fit below the address limit.
// ----------------------------------------------------------------------------
`default_nettype none

module pert_field_chk (
  input  wire logic [pert_pkg::BASE_W-1:0] base_address,
  input  wire logic [pert_pkg::BUS_W-1:0]  first_bus,
  input  wire logic [pert_pkg::BUS_W-1:0]  last_bus,
  output logic                             bad
);

  localparam int SW = pert_pkg::ADDR_LIMIT_BITS + 1;
  localparam logic [SW-1:0] LIMIT = SW'(1) << pert_pkg::ADDR_LIMIT_BITS;

  logic [pert_pkg::BUS_W:0] bus_count;
  logic [SW-1:0]            span_bytes;
  logic [SW-1:0]            span_end;
  logic                     base_high;

  always_comb begin
    bus_count = {1'b0, last_bus} + 9'd1;
    span_bytes = SW'(bus_count) << pert_pkg::MIB_SHIFT;
    span_end = {1'b0, base_address[pert_pkg::ADDR_LIMIT_BITS-1:0]} + span_bytes;
    base_high = |base_address[pert_pkg::BASE_W-1:pert_pkg::ADDR_LIMIT_BITS];
    bad = (base_address == '0) ||
          ((base_address & pert_pkg::ALIGN_MASK) != '0) ||
          (first_bus > last_bus) ||
          base_high ||
          (span_end > LIMIT);
  end

endmodule

`default_nettype wire

// File: rtl/pcie_ecam_region_table_unit.sv
// ----------------------------------------------------------------------------
// pcie_ecam_region_table_unit: ECAM region table
// Checks offered configuration-space regions and keeps the accepted ones.
// ----------------------------------------------------------------------------
// A word is offered by raising start while busy is low. With mode at add,
// the word carries a base address, segment and bus range; the block counts
// it, checks the fields, scans the stored regions for a bus overlap in the
// same segment and, if the table has room, stores it in the next free slot.
// With mode at clear, the table and both counters are emptied.
// Exactly one result word follows each accepted word. It is shown for one
// cycle with done high, and the receiver cannot hold it off.
// A clear or a word with bad fields is answered from the check state.
// Otherwise the stored regions are read one per cycle from the region
// memory until an overlap is found or all of them have been read.
// Busy falls as done rises, so the next word can be accepted at the edge
// that ends the done cycle.
// Reset empties the table and zeroes the counters; memory contents are not
// cleared, as only slots below the stored count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module pcie_ecam_region_table_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              mode,
  input  wire logic [pert_pkg::BASE_W-1:0]       base_address,
  input  wire logic [pert_pkg::SEG_W-1:0]        segment,
  input  wire logic [pert_pkg::BUS_W-1:0]        first_bus,
  input  wire logic [pert_pkg::BUS_W-1:0]        last_bus,
  output logic                                   done,
  output logic      [pert_pkg::STATUS_W-1:0]     status,
  output logic      [pert_pkg::SLOT_W-1:0]       slot,
  output logic      [pert_pkg::STORED_W-1:0]     stored_count,
  output logic      [pert_pkg::COUNT_W-1:0]      seen_count,
  output logic      [pert_pkg::COUNT_W-1:0]      reject_count
);

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_SCAN} state_t;

  state_t                          state;
  logic                            mode_q;
  logic [pert_pkg::BASE_W-1:0]     base_q;
  logic [pert_pkg::SEG_W-1:0]      seg_q;
  logic [pert_pkg::BUS_W-1:0]      first_q;
  logic [pert_pkg::BUS_W-1:0]      last_q;
  logic [pert_pkg::CNT_W-1:0]      held;
  logic [pert_pkg::CNT_W-1:0]      idx;
  logic                            pend;
  logic [pert_pkg::COUNT_W-1:0]    seen;
  logic [pert_pkg::COUNT_W-1:0]    refused;

  logic                            bad;
  logic                            rd_en;
  logic                            wr_en;
  logic [pert_pkg::ENTRY_W-1:0]    rd_data;
  logic [pert_pkg::ENTRY_W-1:0]    wr_data;
  logic                            hit;
  logic                            scan_end;
  logic                            full;

  pert_field_chk u_field_chk (
    .base_address (base_q),
    .first_bus    (first_q),
    .last_bus     (last_q),
    .bad          (bad)
  );

  pert_ram #(
    .WIDTH (pert_pkg::ENTRY_W),
    .DEPTH (pert_pkg::TABLE_DEPTH)
  ) u_region_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (held[pert_pkg::ADDR_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx[pert_pkg::ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    hit = pend && (rd_data[pert_pkg::SEG_W-1:0] == seg_q) &&
          (first_q <= rd_data[pert_pkg::ENTRY_W-1:pert_pkg::SEG_W+pert_pkg::BUS_W]) &&
          (rd_data[pert_pkg::SEG_W+pert_pkg::BUS_W-1:pert_pkg::SEG_W] <= last_q);
    full = (held == pert_pkg::CNT_W'(pert_pkg::TABLE_DEPTH));
    scan_end = !pend && (idx == held);
    rd_en = (state == S_SCAN) && (idx < held) && !hit;
    wr_en = (state == S_SCAN) && scan_end && !full;
    wr_data = {last_q, first_q, seg_q};
    busy = (state != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      held <= '0;
      idx <= '0;
      pend <= 1'b0;
      seen <= '0;
      refused <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            mode_q <= mode;
            base_q <= base_address;
            seg_q <= segment;
            first_q <= first_bus;
            last_q <= last_bus;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (mode_q == pert_pkg::MODE_CLEAR) begin
            held <= '0;
            seen <= '0;
            refused <= '0;
            done <= 1'b1;
            status <= pert_pkg::ST_CLEARED;
            slot <= '0;
            stored_count <= '0;
            seen_count <= '0;
            reject_count <= '0;
            state <= S_IDLE;
          end else if (bad) begin
            seen <= pert_pkg::sat_inc(seen);
            refused <= pert_pkg::sat_inc(refused);
            done <= 1'b1;
            status <= pert_pkg::ST_BAD;
            slot <= '0;
            stored_count <= pert_pkg::STORED_W'(held);
            seen_count <= pert_pkg::sat_inc(seen);
            reject_count <= pert_pkg::sat_inc(refused);
            state <= S_IDLE;
          end else begin
            seen <= pert_pkg::sat_inc(seen);
            idx <= '0;
            pend <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend <= rd_en;
          if (rd_en) begin
            idx <= idx + pert_pkg::CNT_W'(1);
          end
          if (hit || scan_end) begin
            done <= 1'b1;
            seen_count <= seen;
            state <= S_IDLE;
            if (hit || full) begin
              refused <= pert_pkg::sat_inc(refused);
              status <= hit ? pert_pkg::ST_OVERLAP : pert_pkg::ST_FULL;
              slot <= '0;
              stored_count <= pert_pkg::STORED_W'(held);
              reject_count <= pert_pkg::sat_inc(refused);
            end else begin
              held <= held + pert_pkg::CNT_W'(1);
              status <= pert_pkg::ST_STORED;
              slot <= pert_pkg::SLOT_W'(held);
              stored_count <= pert_pkg::STORED_W'(held + pert_pkg::CNT_W'(1));
              reject_count <= refused;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/pert_checker.sv
// ----------------------------------------------------------------------------
// pert_checker: port-level checks for the ECAM region table
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pert_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic                              done,
  input wire logic [pert_pkg::STATUS_W-1:0]     status,
  input wire logic [pert_pkg::SLOT_W-1:0]       slot,
  input wire logic [pert_pkg::STORED_W-1:0]     stored_count,
  input wire logic [pert_pkg::COUNT_W-1:0]      seen_count,
  input wire logic [pert_pkg::COUNT_W-1:0]      reject_count
);

  // An accepted word keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not make the block busy");

  // Every word gives one result, so results never come back to back.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in consecutive cycles");

  // A refused or cleared word reports slot zero.
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status != pert_pkg::ST_STORED) |-> slot == '0)
    else $error("nonzero slot on a word that was not stored");

  // A clear reports an empty table and zeroed counters.
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status == pert_pkg::ST_CLEARED) |->
      (stored_count == '0) && (seen_count == '0) && (reject_count == '0))
    else $error("clear result with nonzero counts");

  // Reset leaves the block idle with no result.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !done)
    else $error("block not idle after reset");

endmodule

bind pcie_ecam_region_table_unit pert_checker u_pert_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .status       (status),
  .slot         (slot),
  .stored_count (stored_count),
  .seen_count   (seen_count),
  .reject_count (reject_count)
);

`default_nettype wire

// File: sim/pcie_ecam_region_table_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcie_ecam_region_table_unit_tb: self-checking testbench for the ECAM table
// A directed table of region words is sent first, followed by random words
// that are mostly well formed. Each result word is compared with its row's typed
// expectation, else with a behavioral model of the table in this testbench.
// ----------------------------------------------------------------------------
module pcie_ecam_region_table_unit_tb;

  localparam int RANDOM_WORDS = 1200;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic                          mode;
    logic [pert_pkg::BASE_W-1:0]   base;
    logic [pert_pkg::SEG_W-1:0]    seg;
    logic [pert_pkg::BUS_W-1:0]    lo_bus;
    logic [pert_pkg::BUS_W-1:0]    hi_bus;
  } region_word_t;

  typedef struct packed {
    logic [pert_pkg::STATUS_W-1:0] status;
    logic [pert_pkg::SLOT_W-1:0]   slot;
    logic [pert_pkg::STORED_W-1:0] stored;
    logic [pert_pkg::COUNT_W-1:0]  seen;
    logic [pert_pkg::COUNT_W-1:0]  rejects;
  } table_result_t;

  typedef struct packed {
    region_word_t  word;
    logic          typed;
    table_result_t want;
  } stim_row_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            start = 1'b0;
  logic                            mode = pert_pkg::MODE_ADD;
  logic [pert_pkg::BASE_W-1:0]     base_address = '0;
  logic [pert_pkg::SEG_W-1:0]      segment = '0;
  logic [pert_pkg::BUS_W-1:0]      first_bus = '0;
  logic [pert_pkg::BUS_W-1:0]      last_bus = '0;
  logic                            busy;
  logic                            done;
  logic [pert_pkg::STATUS_W-1:0]   status;
  logic [pert_pkg::SLOT_W-1:0]     slot;
  logic [pert_pkg::STORED_W-1:0]   stored_count;
  logic [pert_pkg::COUNT_W-1:0]    seen_count;
  logic [pert_pkg::COUNT_W-1:0]    reject_count;

  // Model of the region table.
  logic [pert_pkg::SEG_W-1:0]      held_seg [pert_pkg::TABLE_DEPTH];
  logic [pert_pkg::BUS_W-1:0]      held_lo [pert_pkg::TABLE_DEPTH];
  logic [pert_pkg::BUS_W-1:0]      held_hi [pert_pkg::TABLE_DEPTH];
  int                              held_n = 0;
  logic [pert_pkg::COUNT_W-1:0]    offered_cnt = '0;
  logic [pert_pkg::COUNT_W-1:0]    refused_cnt = '0;

  table_result_t                   pending_results[$];
  int                              mismatches = 0;
  int                              stall_cycles = 0;
  logic                            quiet_stretch = 1'b0;

  pcie_ecam_region_table_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .base_address (base_address),
    .segment      (segment),
    .first_bus    (first_bus),
    .last_bus     (last_bus),
    .done         (done),
    .status       (status),
    .slot         (slot),
    .stored_count (stored_count),
    .seen_count   (seen_count),
    .reject_count (reject_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [pert_pkg::COUNT_W-1:0] bump_saturating(
    input logic [pert_pkg::COUNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic region_fields_bad(input region_word_t w);
    logic [pert_pkg::BASE_W-1:0] limit;
    logic [pert_pkg::BASE_W-1:0] span;
    limit = 64'd1 << pert_pkg::ADDR_LIMIT_BITS;
    span = (pert_pkg::BASE_W'(w.hi_bus) + 64'd1) << pert_pkg::MIB_SHIFT;
    if (w.base == '0 || (w.base & pert_pkg::ALIGN_MASK) != '0) return 1'b1;
    if (w.lo_bus > w.hi_bus) return 1'b1;
    if (w.base >= limit) return 1'b1;
    return span > limit - w.base;
  endfunction

  function automatic table_result_t apply_region_word(input region_word_t w);
    table_result_t r;
    r = '0;
    if (w.mode == pert_pkg::MODE_CLEAR) begin
      held_n = 0;
      offered_cnt = '0;
      refused_cnt = '0;
      r.status = pert_pkg::ST_CLEARED;
    end else begin
      offered_cnt = bump_saturating(offered_cnt);
      if (region_fields_bad(w)) begin
        r.status = pert_pkg::ST_BAD;
      end else begin
        r.status = pert_pkg::ST_STORED;
        for (int i = 0; i < held_n; i++) begin
          if (held_seg[i] == w.seg && w.lo_bus <= held_hi[i] && held_lo[i] <= w.hi_bus) begin
            r.status = pert_pkg::ST_OVERLAP;
          end
        end
        if (r.status == pert_pkg::ST_STORED && held_n >= pert_pkg::TABLE_DEPTH) begin
          r.status = pert_pkg::ST_FULL;
        end
      end
      if (r.status == pert_pkg::ST_STORED) begin
        r.slot = pert_pkg::SLOT_W'(held_n);
        held_seg[held_n] = w.seg;
        held_lo[held_n] = w.lo_bus;
        held_hi[held_n] = w.hi_bus;
        held_n++;
      end else begin
        refused_cnt = bump_saturating(refused_cnt);
      end
    end
    r.stored = pert_pkg::STORED_W'(held_n);
    r.seen = offered_cnt;
    r.rejects = refused_cnt;
    return r;
  endfunction

  function automatic region_word_t rw(input logic m, input logic [pert_pkg::BASE_W-1:0] b,
                                      input logic [pert_pkg::SEG_W-1:0] s,
                                      input logic [pert_pkg::BUS_W-1:0] lo,
                                      input logic [pert_pkg::BUS_W-1:0] hi);
    region_word_t w;
    w.mode = m;
    w.base = b;
    w.seg = s;
    w.lo_bus = lo;
    w.hi_bus = hi;
    return w;
  endfunction

  function automatic table_result_t tr(input logic [pert_pkg::STATUS_W-1:0] st,
                                       input int sl,
                                       input int sc,
                                       input int seen,
                                       input int rej);
    table_result_t r;
    r.status = st;
    r.slot = pert_pkg::SLOT_W'(sl);
    r.stored = pert_pkg::STORED_W'(sc);
    r.seen = pert_pkg::COUNT_W'(seen);
    r.rejects = pert_pkg::COUNT_W'(rej);
    return r;
  endfunction

  function automatic region_word_t random_region_word();
    region_word_t w;
    int unsigned pick;
    int unsigned widen;
    logic [31:0] base_mib;
    pick = $urandom_range(0, 99);
    w.mode = pert_pkg::MODE_ADD;
    w.seg = ($urandom_range(0, 4) == 0) ? pert_pkg::SEG_W'($urandom) :
                                          pert_pkg::SEG_W'($urandom_range(0, 3));
    w.lo_bus = pert_pkg::BUS_W'($urandom);
    widen = 255 - w.lo_bus;
    if (widen > 7) widen = 7;
    w.hi_bus = ($urandom_range(0, 9) == 0) ? 8'hff :
               w.lo_bus + pert_pkg::BUS_W'($urandom_range(0, widen));
    base_mib = $urandom_range(1, 32'hffff_ffff - w.hi_bus);
    if ($urandom_range(0, 19) == 0) base_mib = 32'hffff_ffff - w.hi_bus;
    w.base = {12'd0, base_mib, 20'd0};
    if (pick < 15) begin
      case ($urandom_range(0, 5))
        0: w.base = {$urandom, $urandom};
        1: w.base[19:0] = 20'($urandom_range(1, 20'hfffff));
        2: begin
          w.lo_bus = pert_pkg::BUS_W'($urandom_range(1, 255));
          w.hi_bus = pert_pkg::BUS_W'($urandom_range(0, w.lo_bus - 1));
        end
        3: w.base = '0;
        4: w.base[63:52] = 12'($urandom_range(1, 4095));
        default: begin
          w.hi_bus = 8'hff;
          w.base = {12'd0, 32'($urandom_range(32'hffff_ff01, 32'hffff_ffff)), 20'd0};
        end
      endcase
    end else if (pick < 18) begin
      w.mode = pert_pkg::MODE_CLEAR;
    end
    return w;
  endfunction

  task automatic send_word(input region_word_t w, input logic typed, input table_result_t want);
    table_result_t r;
    if (!quiet_stretch) begin
      while ($urandom_range(0, 99) < 10) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    mode <= w.mode;
    base_address <= w.base;
    segment <= w.seg;
    first_bus <= w.lo_bus;
    last_bus <= w.hi_bus;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = apply_region_word(w);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    table_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result word with no pending expectation");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(want.status), 64'(status));
        check_field("slot", 64'(want.slot), 64'(slot));
        check_field("stored_count", 64'(want.stored), 64'(stored_count));
        check_field("seen_count", 64'(want.seen), 64'(seen_count));
        check_field("reject_count", 64'(want.rejects), 64'(reject_count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("pcie_ecam_region_table_unit_tb: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t rows[$];
    logic [pert_pkg::BASE_W-1:0] top_mib;
    top_mib = (64'd1 << pert_pkg::ADDR_LIMIT_BITS) - (64'd1 << pert_pkg::MIB_SHIFT);
    rows.push_back('{rw(pert_pkg::MODE_CLEAR, '0, '0, '0, '0), 1'b1,
                     tr(pert_pkg::ST_CLEARED, 0, 0, 0, 0)});
    rows.push_back('{rw(pert_pkg::MODE_ADD, '0, '0, '0, '0), 1'b1,
                     tr(pert_pkg::ST_BAD, 0, 0, 1, 1)});
    rows.push_back('{rw(pert_pkg::MODE_ADD, 64'h10_0001, '0, '0, '0), 1'b1,
                     tr(pert_pkg::ST_BAD, 0, 0, 2, 2)});
    rows.push_back('{rw(pert_pkg::MODE_ADD, 64'h10_0000, '0, 8'd5, 8'd4), 1'b1,
                     tr(pert_pkg::ST_BAD, 0, 0, 3, 3)});
    rows.push_back('{rw(pert_pkg::MODE_ADD, 64'd1 << pert_pkg::ADDR_LIMIT_BITS, '0, '0, '0),
                     1'b1, tr(pert_pkg::ST_BAD, 0, 0, 4, 4)});
    rows.push_back('{rw(pert_pkg::MODE_ADD, '1, '1, '1, '1), 1'b1,
                     tr(pert_pkg::ST_BAD, 0, 0, 5, 5)});
    rows.push_back('{rw(pert_pkg::MODE_ADD, top_mib, '0, '0, '0), 1'b1,
                     tr(pert_pkg::ST_STORED, 0, 1, 6, 5)});
    rows.push_back('{rw(pert_pkg::MODE_ADD, top_mib, 16'd1, '0, 8'd1), 1'b1,
                     tr(pert_pkg::ST_BAD, 0, 1, 7, 6)});
    rows.push_back('{rw(pert_pkg::MODE_ADD, 64'h1000_0000, '1, '0, '1), 1'b1,
                     tr(pert_pkg::ST_STORED, 1, 2, 8, 6)});
    rows.push_back('{rw(pert_pkg::MODE_ADD, 64'h20_0000, '1, '1, '1), 1'b1,
                     tr(pert_pkg::ST_OVERLAP, 0, 2, 9, 7)});
    for (int i = 1; i <= 14; i++) begin
      rows.push_back('{rw(pert_pkg::MODE_ADD, 64'(i) << pert_pkg::MIB_SHIFT, '0,
                          pert_pkg::BUS_W'(i), pert_pkg::BUS_W'(i)), 1'b0, '0});
    end
    rows.push_back('{rw(pert_pkg::MODE_ADD, 64'h40_0000, 16'd5, '0, 8'd9), 1'b0, '0});
    rows.push_back('{rw(pert_pkg::MODE_ADD, 64'h40_0000, '0, 8'd3, 8'd3), 1'b0, '0});
    rows.push_back('{rw(pert_pkg::MODE_ADD, '0, 16'd5, '0, '0), 1'b0, '0});
    rows.push_back('{rw(pert_pkg::MODE_CLEAR, '1, '1, '1, '1), 1'b1,
                     tr(pert_pkg::ST_CLEARED, 0, 0, 0, 0)});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[i]) begin
      send_word(rows[i].word, rows[i].typed, rows[i].want);
    end
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      quiet_stretch = (n >= 300 && n < 700);
      send_word(random_region_word(), 1'b0, '0);
    end
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("pcie_ecam_region_table_unit_tb: PASS");
    end else begin
      $display("pcie_ecam_region_table_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/pert_pkg.sv
rtl/pert_ram.sv
rtl/pert_field_chk.sv
rtl/pcie_ecam_region_table_unit.sv
rtl/pert_checker.sv
sim/pcie_ecam_region_table_unit_tb.sv
